/* rtl/core/stc_pkg.sv */
// Shared types and constants for the solarize tone curve block.
// Used by the curve table builder and the top level; depends on nothing.

package stc_pkg;

  // Channel and level geometry
  localparam int CHAN_W    = 8;
  localparam int NCHAN     = 3;
  localparam int LEVEL_W   = 9;
  localparam int PIX_IN_W  = 32;
  localparam int PIX_W     = NCHAN * CHAN_W;
  localparam int CFG_IDX_W = 2;

  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [LEVEL_W-1:0] level_t;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PEAK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END   = 2'd2;

  // Register values after reset
  localparam level_t RST_PEAK  = 9'd127;
  localparam level_t RST_START = 9'd50;
  localparam level_t RST_END   = 9'd185;

  // Output clamp
  localparam chan_t CHAN_MAX = 8'hFF;

  // One write into the curve table
  typedef struct packed {
    logic  en;
    chan_t addr;
    chan_t data;
  } stc_wr_t;

endpackage

/* rtl/core/stc_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.

module stc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/stc_fill.sv */
// Curve table builder: sweeps all 256 input levels, evaluates the solarize
// curve through a pipelined clamped divider and emits table writes.
// Depends on stc_pkg.

module stc_fill
  import stc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    restart,
  input  level_t  peak_level,
  input  level_t  ramp_start,
  input  level_t  ramp_end,
  output logic    ready,
  output stc_wr_t wr
);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam int DIV_STEPS = LEVEL_W;
  localparam int NUM_W     = 32;
  localparam int NSTG      = CHAN_W + 2;   // issue, saturate check, one per quotient bit
  localparam int WIDE_W    = NUM_W + CHAN_W;
  localparam int N_W       = 21;           // signed numerator before extension

  logic [2:0]          state;
  logic [3:0]          cnt;
  chan_t               c;
  logic [LEVEL_W-1:0]  per_abs;
  logic signed [9:0]   up, down, x, p;
  logic [LEVEL_W-1:0]  xs, rem;
  logic                x_neg;

  // Derived lengths from the registers, zero lengths forced to one
  logic signed [9:0] period_d, up_d, down_d, per_neg, x0_d, x0_neg;
  always_comb begin
    period_d = $signed({1'b0, ramp_end}) - $signed({1'b0, ramp_start});
    up_d     = $signed({1'b0, peak_level}) - $signed({1'b0, ramp_start});
    down_d   = $signed({1'b0, ramp_end}) - $signed({1'b0, peak_level});
    if (period_d == 10'sd0) period_d = 10'sd1;
    if (up_d == 10'sd0)     up_d     = 10'sd1;
    if (down_d == 10'sd0)   down_d   = 10'sd1;
    per_neg = -period_d;
    x0_d    = 10'sd256 - $signed({1'b0, ramp_start});
    x0_neg  = -x0_d;
  end

  // One restoring step of the initial remainder |x0| mod |period|
  logic [LEVEL_W:0]   r2, r2_sub;
  logic               r2_ge;
  logic [LEVEL_W-1:0] rem_next;
  logic signed [9:0]  rem_sg, p_init;
  always_comb begin
    r2       = {rem, xs[LEVEL_W-1]};
    r2_sub   = r2 - {1'b0, per_abs};
    r2_ge    = r2 >= {1'b0, per_abs};
    rem_next = r2_ge ? r2_sub[LEVEL_W-1:0] : r2[LEVEL_W-1:0];
    rem_sg   = $signed({1'b0, rem_next});
    p_init   = x_neg ? -rem_sg : rem_sg;
  end

  // Curve numerator and denominator for the current level
  logic                   lt;
  logic signed [11:0]     t12, sel;
  logic signed [N_W-1:0]  sel21, n21;
  logic signed [9:0]      den10, pm1, p_step;
  logic [NUM_W-1:0]       num32, den32;
  always_comb begin
    lt    = p < up;
    t12   = $signed({{2{down[9]}}, down}) - $signed({{2{p[9]}}, p})
          + $signed({{2{up[9]}}, up});
    sel   = lt ? $signed({{2{p[9]}}, p}) : t12;
    sel21 = {{(N_W-12){sel[11]}}, sel};
    n21   = $signed({sel21[N_W-9:0], 8'b0}) - sel21;   // times 255
    den10 = lt ? up : down;
    num32 = {{(NUM_W-N_W){n21[N_W-1]}}, n21};
    den32 = {{(NUM_W-10){den10[9]}}, den10};
    // Truncating remainder of the next level, stepped by one
    pm1 = $signed({1'b0, per_abs - 9'd1});
    if (x[9] && p == 10'sd0) begin
      p_step = -pm1;
    end else if (!x[9] && p == pm1) begin
      p_step = 10'sd0;
    end else begin
      p_step = p + 10'sd1;
    end
  end

  // Clamped divider pipeline
  logic [NSTG-1:0]  vld;
  logic [NSTG-1:0]  sat_s, sat_n;
  chan_t            addr_s [NSTG];
  logic [NUM_W-1:0] rem_s  [NSTG];
  logic [NUM_W-1:0] den_s  [NSTG];
  chan_t            q_s    [NSTG];
  logic [NUM_W-1:0] rem_n  [NSTG];
  chan_t            q_n    [NSTG];

  always_comb begin
    logic [WIDE_W-1:0] trial, diff;
    logic              ge;
    rem_n[0] = num32;
    q_n[0]   = '0;
    sat_n[0] = 1'b0;
    for (int k = 1; k < NSTG; k++) begin
      rem_n[k] = rem_s[k-1];
      q_n[k]   = q_s[k-1];
      sat_n[k] = sat_s[k-1];
      trial    = {{CHAN_W{1'b0}}, den_s[k-1]} << (NSTG - 1 - k);
      if (k == 1) begin
        trial    = {den_s[k-1], {CHAN_W{1'b0}}};
        sat_n[k] = {{CHAN_W{1'b0}}, rem_s[k-1]} >= trial;
      end else begin
        ge       = {{CHAN_W{1'b0}}, rem_s[k-1]} >= trial;
        diff     = {{CHAN_W{1'b0}}, rem_s[k-1]} - trial;
        rem_n[k] = ge ? diff[NUM_W-1:0] : rem_s[k-1];
        q_n[k]   = {q_s[k-1][CHAN_W-2:0], ge};
      end
    end
  end

  // Sequencer and pipeline registers
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= ST_LOAD;
      vld   <= '0;
    end else begin
      vld <= {vld[NSTG-2:0], state == ST_SWEEP};
      unique case (state)
        ST_LOAD: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt == 4'(DIV_STEPS - 1)) begin
            state <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          if (c == CHAN_MAX) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (vld == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          state <= ST_DONE;
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end

    // Datapath, no reset
    case (state)
      ST_LOAD: begin
        per_abs <= period_d[9] ? per_neg[LEVEL_W-1:0] : period_d[LEVEL_W-1:0];
        up      <= up_d;
        down    <= down_d;
        x       <= x0_d;
        x_neg   <= x0_d[9];
        xs      <= x0_d[9] ? x0_neg[LEVEL_W-1:0] : x0_d[LEVEL_W-1:0];
        rem     <= '0;
        cnt     <= '0;
      end
      ST_DIV: begin
        rem <= rem_next;
        xs  <= {xs[LEVEL_W-2:0], 1'b0};
        cnt <= cnt + 4'd1;
        p   <= p_init;
        c   <= '0;
      end
      ST_SWEEP: begin
        p <= p_step;
        x <= x + 10'sd1;
        c <= c + 8'd1;
      end
      default: begin
      end
    endcase

    addr_s[0] <= c;
    den_s[0]  <= den32;
    for (int k = 1; k < NSTG; k++) begin
      addr_s[k] <= addr_s[k-1];
      den_s[k]  <= den_s[k-1];
    end
    for (int k = 0; k < NSTG; k++) begin
      rem_s[k] <= rem_n[k];
      q_s[k]   <= q_n[k];
    end
    sat_s <= sat_n;
  end

  assign ready   = state == ST_DONE;
  assign wr.en   = vld[NSTG-1];
  assign wr.addr = addr_s[NSTG-1];
  assign wr.data = sat_s[NSTG-1] ? CHAN_MAX : q_s[NSTG-1];

  // The table is only declared ready once every entry has left the divider
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    ready |-> vld == '0)
    else $error("table ready with divider entries in flight");

  // A register write always starts a fresh sweep
  a_restart_busy: assert property (@(posedge clk) disable iff (rst)
    restart |=> !ready)
    else $error("table still ready after restart");

endmodule

/* rtl/core/solarize_tone_curve.sv */
// Solarize tone curve: maps each 8-bit channel of a pixel through a
// triangular curve held in three table RAM banks.
// Depends on stc_pkg, stc_fill and stc_ram.
//
// Usage:
//   Pixels enter on the s_ stream (tdata = 32-bit pixel, tlast = frame end)
//   and leave on the m_ stream (tdata = 24-bit pixel, tlast copied).
//   Each channel is looked up in its own copy of a 256-entry curve table,
//   so one pixel is taken every clock while s_tready is high. Between input
//   request and output valid lie the registered table read and the queue.
//   A 4-entry output queue sits after the table read; s_tready stays high
//   while m_tready is low until the queue and the read in flight fill it,
//   then drops. No request is lost or repeated under stalls.
//   Registers are written on the cfg_ port (index 0 peak_level,
//   1 ramp_start, 2 ramp_end). After rst, and after every write to one of
//   these registers, the table is rebuilt (set-up, a 9-step remainder,
//   256 levels through a 10-stage divider pipeline), during which s_tready
//   is low. cfg_ready is always high.

module solarize_tone_curve
  import stc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [PIX_IN_W-1:0]  s_tdata,     // [31:0] pixel_in
  input  logic                 s_tlast,     // in_last
  // output stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [PIX_W-1:0]     m_tdata,     // [23:0] pixel_out
  output logic                 m_tlast,     // out_last
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEVEL_W-1:0]   cfg_data
);

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 2);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } oq_item_t;

  level_t  peak_level, ramp_start, ramp_end;
  logic    cfg_fire, cfg_hit, tbl_ready, accept, pop, push;
  stc_wr_t wr;

  // Register file
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_index == REG_PEAK || cfg_index == REG_START
                  || cfg_index == REG_END;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_level <= RST_PEAK;
      ramp_start <= RST_START;
      ramp_end   <= RST_END;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_PEAK:  peak_level <= cfg_data;
        REG_START: ramp_start <= cfg_data;
        REG_END:   ramp_end   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Table builder
  stc_fill u_fill (
    .clk        (clk),
    .rst        (rst),
    .restart    (cfg_fire && cfg_hit),
    .peak_level (peak_level),
    .ramp_start (ramp_start),
    .ramp_end   (ramp_end),
    .ready      (tbl_ready),
    .wr         (wr)
  );

  // One table bank per channel
  chan_t            rd_chan [NCHAN];
  logic [PIX_W-1:0] rd_pixel;

  for (genvar ch = 0; ch < NCHAN; ch++) begin : g_bank
    stc_ram #(
      .WIDTH (CHAN_W),
      .DEPTH (1 << CHAN_W)
    ) u_bank (
      .clk     (clk),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (accept),
      .rd_addr (s_tdata[ch*CHAN_W +: CHAN_W]),
      .rd_data (rd_chan[ch])
    );
  end

  always_comb begin
    for (int ch = 0; ch < NCHAN; ch++) begin
      rd_pixel[ch*CHAN_W +: CHAN_W] = rd_chan[ch];
    end
  end

  // Table read in flight
  logic rd_vld, rd_last;
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= accept;
    end
    if (accept) begin
      rd_last <= s_tlast;
    end
  end

  // Output queue
  oq_item_t         oq [OQ_DEPTH];
  logic [OQ_AW-1:0] wptr, rptr;
  logic [OQ_CW-1:0] count, occ;

  assign push     = rd_vld;
  assign pop      = m_tvalid && m_tready;
  assign occ      = count + {{(OQ_CW-1){1'b0}}, rd_vld};
  assign s_tready = tbl_ready && (occ < OQ_CW'(OQ_DEPTH));
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
    if (push) begin
      oq[wptr] <= '{pixel: rd_pixel, last: rd_last};
    end
  end

  assign m_tvalid = count != '0;
  assign m_tdata  = oq[rptr].pixel;
  assign m_tlast  = oq[rptr].last;

  // A finished table read always finds a free queue slot
  a_oq_room: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> count < OQ_CW'(OQ_DEPTH))
    else $error("output queue overflow");

  // The table is never written while a pixel is looked up
  a_no_mixed: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> !accept)
    else $error("table write during pixel lookup");

  // A register write stops pixel intake while the table is rebuilt
  a_cfg_stall: assert property (@(posedge clk) disable iff (rst)
    (cfg_fire && cfg_hit) |=> !s_tready)
    else $error("pixels taken during table rebuild");

endmodule

/* tb/tb_solarize_tone_curve.sv */
// Self-checking testbench for solarize_tone_curve: random pixel streams under
// many register settings, checked against a local model of the curve.
// Depends on stc_pkg and the solarize_tone_curve RTL.
`timescale 1ns / 1ps

module tb_solarize_tone_curve;
  import stc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 57;
  localparam int RAND_PHASES = 13;
  localparam int HOLD_CYCLES = 300;
  localparam int SHOW_MAX    = 10;
  // index 3 maps to no register; writes there must leave the curve alone
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    bit [PIX_W-1:0] px;
    bit             last;
  } shade_t;

  // Holds the curve levels and the solarized pixels still owed by the block
  class curve_ledger;
    bit [LEVEL_W-1:0] lv_peak  = RST_PEAK;
    bit [LEVEL_W-1:0] lv_start = RST_START;
    bit [LEVEL_W-1:0] lv_stop  = RST_END;
    shade_t pending_px[$];
    int unsigned errors;

    function void set_level(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] val);
      case (idx)
        REG_PEAK:  lv_peak = val;
        REG_START: lv_start = val;
        REG_END:   lv_stop = val;
        default: ;
      endcase
    endfunction

    // Triangular curve for one channel; products wrap to 32 bits and
    // divisions are unsigned, and quotients above 255 clamp to 255
    function bit [CHAN_W-1:0] curve_level(bit [CHAN_W-1:0] c);
      longint s, period, rise, fall, p, tail;
      bit [31:0] num, den, v;
      s      = lv_start;
      period = longint'(lv_stop) - s;
      rise   = longint'(lv_peak) - s;
      fall   = longint'(lv_stop) - longint'(lv_peak);
      if (period == 0) period = 1;
      if (rise == 0) rise = 1;
      if (fall == 0) fall = 1;
      p = (longint'(c) + 256 - s) % period;
      if (p < rise) begin
        num = p * 255;
        den = rise;
      end else begin
        tail = fall - (p - rise);
        num  = tail * 255;
        den  = fall;
      end
      v = num / den;
      return (v > 255) ? CHAN_MAX : v[CHAN_W-1:0];
    endfunction

    function void note_pixel(bit [PIX_IN_W-1:0] pix, bit last);
      shade_t sh;
      sh.px   = {curve_level(pix[23:16]), curve_level(pix[15:8]), curve_level(pix[7:0])};
      sh.last = last;
      pending_px.push_back(sh);
    endfunction

    function void check_pixel(logic [PIX_W-1:0] px, logic last);
      shade_t sh;
      if (pending_px.size() == 0) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("%0t: pixel %h last %b out with none pending", $realtime, px, last);
        return;
      end
      sh = pending_px.pop_front();
      if (px !== sh.px || last !== sh.last) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("%0t: pixel expected %h last %b, got %h last %b",
                   $realtime, sh.px, sh.last, px, last);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [PIX_IN_W-1:0]  s_tdata;
  logic                 s_tlast;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [PIX_W-1:0]     m_tdata;
  logic                 m_tlast;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEVEL_W-1:0]   cfg_data;

  curve_ledger ledger = new;
  int unsigned cyc;
  int tx_max = 16;
  int rx_max = 16;
  bit hold_req;

  solarize_tone_curve u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Cycle count and run limit
  always @(posedge clk) cyc <= cyc + 1;

  initial begin
    wait (cyc >= CYCLE_LIMIT);
    $display("solarize_tone_curve: mismatch");
    $finish;
  end

  // Output check on every accepted result
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      ledger.check_pixel(m_tdata, m_tlast);
  end

  // Receiver: random back-pressure per result, long hold on request
  initial begin : rx_side
    int gap;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        gap = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        gap = (rx_max == 0) ? 0 : $urandom_range(rx_max);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // One pixel request; s_tvalid stays high when no gap follows
  task automatic send_pixel(bit [PIX_IN_W-1:0] pix, bit last);
    int gap;
    s_tdata  <= pix;
    s_tlast  <= last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    ledger.note_pixel(pix, last);
    gap = (tx_max == 0) ? 0 : $urandom_range(tx_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write all three levels back to back, optionally poking the spare index
  task automatic load_levels(bit [LEVEL_W-1:0] pk, bit [LEVEL_W-1:0] st,
                             bit [LEVEL_W-1:0] sp, bit poke_spare);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [LEVEL_W-1:0]   val [4];
    int n;
    idx[0] = REG_PEAK;  val[0] = pk;
    idx[1] = REG_START; val[1] = st;
    idx[2] = REG_END;   val[2] = sp;
    idx[3] = REG_SPARE; val[3] = $urandom_range(511);
    n = poke_spare ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      ledger.set_level(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Stop offering and wait until every pixel has come back
  task automatic drain;
    s_tvalid <= 1'b0;
    while (ledger.pending_px.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Channel value biased toward 0, 255 and the curve's break points
  function automatic bit [CHAN_W-1:0] pick_channel();
    bit [CHAN_W-1:0] base;
    if ($urandom_range(3) != 0) return $urandom_range(255);
    case ($urandom_range(4))
      0: base = 8'h00;
      1: base = 8'hFF;
      2: base = ledger.lv_start[7:0];
      3: base = ledger.lv_peak[7:0];
      default: base = ledger.lv_stop[7:0];
    endcase
    return base + $urandom_range(2) - 1;
  endfunction

  function automatic bit [LEVEL_W-1:0] pick_level(bit [LEVEL_W-1:0] other);
    case ($urandom_range(7))
      5: return $urandom_range(511);
      6: return $urandom_range(1) ? 9'd256 : 9'd0;
      7: return other;
      default: return $urandom_range(256);
    endcase
  endfunction

  task automatic run_phase(int count);
    bit [PIX_IN_W-1:0] pix;
    for (int i = 0; i < count; i++) begin
      pix = {8'($urandom_range(255)), pick_channel(), pick_channel(), pick_channel()};
      send_pixel(pix, $urandom_range(7) == 0);
    end
  endtask

  // Fixed level settings: coinciding levels, reversed order, above 256
  bit [LEVEL_W-1:0] fixed_lv [15][3] = '{
    '{9'd0,   9'd0,   9'd256}, '{9'd256, 9'd0,   9'd256}, '{9'd128, 9'd0,   9'd256},
    '{9'd0,   9'd0,   9'd0},   '{9'd256, 9'd256, 9'd256}, '{9'd100, 9'd100, 9'd100},
    '{9'd100, 9'd50,  9'd50},  '{9'd50,  9'd50,  9'd200}, '{9'd200, 9'd50,  9'd200},
    '{9'd10,  9'd200, 9'd5},   '{9'd511, 9'd511, 9'd511}, '{9'd300, 9'd0,   9'd511},
    '{9'd0,   9'd511, 9'd0},   '{9'd256, 9'd0,   9'd0},   '{9'd1,   9'd255, 9'd128}
  };

  bit [PIX_IN_W-1:0] first_px [12] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'hFF00_FF00, 32'h00FF_00FF,
    32'h0032_7FB9, 32'h8031_80B8, 32'h0033_7EBA, 32'h5501_FE00,
    32'hAA12_3456, 32'h0001_0203, 32'h7F80_7F80, 32'h01FE_01FE
  };

  // Main sequence
  initial begin : stim
    bit [LEVEL_W-1:0] pk, st, sp;
    int mode [4] = '{16, 16, 0, 3};
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_PEAK;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset levels, edge pixels
    for (int i = 0; i < 12; i++) send_pixel(first_px[i], i[0]);
    drain();

    for (int ph = 0; ph < 15 + RAND_PHASES; ph++) begin
      if (ph < 15) begin
        pk = fixed_lv[ph][0];
        st = fixed_lv[ph][1];
        sp = fixed_lv[ph][2];
      end else begin
        st = pick_level($urandom_range(256));
        pk = pick_level(st);
        sp = pick_level($urandom_range(1) ? st : pk);
      end
      load_levels(pk, st, sp, ph == 0 || $urandom_range(3) == 0);
      tx_max = mode[$urandom_range(3)];
      rx_max = mode[$urandom_range(3)];
      // long receiver hold while pixels keep coming
      if (ph == 2 || ph == 20) begin
        tx_max   = 0;
        hold_req = 1'b1;
      end
      run_phase(PHASE_ITEMS);
      drain();
    end

    repeat (10) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending_px.size() == 0) begin
      $display("solarize_tone_curve: match");
    end else begin
      $display("solarize_tone_curve: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/stc_pkg.sv
rtl/core/stc_ram.sv
rtl/core/stc_fill.sv
rtl/core/solarize_tone_curve.sv
tb/tb_solarize_tone_curve.sv
